// File: design/gf4096_poly_mul_mod_defines.svh
// Assertion macros for the gf4096_poly_mul_mod checker.
// No dependencies.
`ifndef GF4096_POLY_MUL_MOD_DEFINES_SVH
`define GF4096_POLY_MUL_MOD_DEFINES_SVH

// implication checked every clock, off during reset
`define GPM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpm check failed");

// next-cycle implication with no reset qualification
`define GPM_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gpm check failed");

`endif

// File: design/gpm_pkg.sv
// Shared constants, types and GF(2^m) helpers for the polynomial multiplier.
// No dependencies.
package gpm_pkg;
   localparam int DEGREE     = 64;
   localparam int FIELD_BITS = 12;
   localparam int CSR_W      = 12;
   localparam int CNT_W      = $clog2(DEGREE);

   typedef logic [FIELD_BITS-1:0] field_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef struct packed {
      logic load;    // shift operands in from the top
      logic clr;     // zero the accumulators
      logic step;    // one Horner step
      logic drain;   // shift results toward cell 0
   } cell_ctrl_type;

   function automatic field_type gf_mul(field_type a, field_type b, field_type poly);
      field_type acc;
      acc = '0;
      for (int k = FIELD_BITS - 1; k >= 0; k--) begin
         acc = {acc[FIELD_BITS-2:0], 1'b0} ^ (acc[FIELD_BITS-1] ? poly : '0);
         if (b[k]) acc = acc ^ a;
      end
      return acc;
   endfunction

   function automatic field_type gf_mul2(field_type t, field_type poly);
      return {t[FIELD_BITS-2:0], 1'b0} ^ (t[FIELD_BITS-1] ? poly : '0);
   endfunction
endpackage

// File: design/gpm_if.sv
// Valid/ready channel interfaces for operand and result beats.
// Depends on gpm_pkg.
interface gpm_req_if import gpm_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type coef_a;
   field_type coef_b;
   modport source (output valid, coef_a, coef_b, input ready);
   modport sink   (input valid, coef_a, coef_b, output ready);
endinterface

interface gpm_rsp_if import gpm_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type coef_out;
   logic      last_out;
   modport source (output valid, coef_out, last_out, input ready);
   modport sink   (input valid, coef_out, last_out, output ready);
endinterface

// File: design/gf4096_poly_mul_mod.sv
// Top level: 64-cell chain computing A*B mod y^64+y^3+y+z over GF(2^12).
// Depends on gpm_pkg, gpm_if, gpm_cell.
//  channel | dir | beat
//  req     | in  | coef_a, coef_b, one pair per beat, lowest degree first
//  rsp     | out | coef_out, last_out, lowest degree first
//  csr     | in  | field_poly_low write, 12 bits
// A round is 64 load beats (one per cycle while req is valid), then Horner
// steps in the chain (b broadcast from the top cell, highest degree first),
// then 64 result beats shifted out of cell 0.
// Reset clears control state and sets the field polynomial to x^12+x^3+1.
// Stalls on rsp hold the drain; req is refused outside the load phase.
module gf4096_poly_mul_mod import gpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   gpm_req_if.sink          req_chan,
   gpm_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   typedef enum logic [1:0] {S_LOAD, S_MUL, S_EMIT} state_type;

   state_type     state_ff;
   cnt_type       cnt_ff;
   field_type     poly_ff;
   cell_ctrl_type ctrl;
   logic          req_acc, rsp_acc, cnt_last;

   field_type a_q   [DEGREE];
   field_type b_q   [DEGREE];
   field_type acc_q [DEGREE];
   field_type top;

   assign cnt_last = (cnt_ff == cnt_type'(DEGREE - 1));
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_acc  = rsp_chan.valid && rsp_chan.ready;
   assign top      = acc_q[DEGREE-1];

   assign req_chan.ready    = (state_ff == S_LOAD);
   assign rsp_chan.valid    = (state_ff == S_EMIT);
   assign rsp_chan.coef_out = acc_q[0];
   assign rsp_chan.last_out = cnt_last;

   always_comb begin
      ctrl.load  = req_acc;
      ctrl.clr   = req_acc && cnt_last;
      ctrl.step  = (state_ff == S_MUL);
      ctrl.drain = rsp_acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         poly_ff  <= field_type'(9);
      end else begin
         if (csr_we) poly_ff <= csr_wdata[FIELD_BITS-1:0];
         unique case (state_ff)
            S_LOAD: if (req_acc) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_last) state_ff <= S_MUL;
            end
            S_MUL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_last) state_ff <= S_EMIT;
            end
            S_EMIT: if (rsp_acc) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_last) state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   for (genvar i = 0; i < DEGREE; i++) begin : g_cell
      field_type a_hi, b_hi, b_lo, acc_lo, acc_hi;
      if (i == DEGREE - 1) begin : g_top
         assign a_hi   = req_chan.coef_a;
         assign b_hi   = req_chan.coef_b;
         assign acc_hi = '0;
      end else begin : g_mid
         assign a_hi   = a_q[i+1];
         assign b_hi   = b_q[i+1];
         assign acc_hi = acc_q[i+1];
      end
      // multiply by y, folding the top term into y^3, y and z*y^0
      if (i == 0) begin : g_z
         assign b_lo   = '0;
         assign acc_lo = gf_mul2(top, poly_ff);
      end else if (i == 1 || i == 3) begin : g_tap
         assign b_lo   = b_q[i-1];
         assign acc_lo = acc_q[i-1] ^ top;
      end else begin : g_plain
         assign b_lo   = b_q[i-1];
         assign acc_lo = acc_q[i-1];
      end
      gpm_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .a_hi    (a_hi),
         .b_hi    (b_hi),
         .b_lo    (b_lo),
         .acc_lo  (acc_lo),
         .acc_hi  (acc_hi),
         .b_bcast (b_q[DEGREE-1]),
         .poly    (poly_ff),
         .a_q     (a_q[i]),
         .b_q     (b_q[i]),
         .acc_q   (acc_q[i])
      );
   end
endmodule

// File: design/gpm_cell.sv
// One cell of the multiplier chain: holds a_i, a b slot and one accumulator term.
// Depends on gpm_pkg.
module gpm_cell import gpm_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  field_type     a_hi,     // a from the cell above (load)
   input  field_type     b_hi,     // b from the cell above (load)
   input  field_type     b_lo,     // b from the cell below (step)
   input  field_type     acc_lo,   // shifted term plus reduction feedback
   input  field_type     acc_hi,   // term from above (drain)
   input  field_type     b_bcast,
   input  field_type     poly,
   output field_type     a_q,
   output field_type     b_q,
   output field_type     acc_q
);
   field_type a_ff, b_ff, acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= a_hi;
         b_ff <= b_hi;
      end else if (ctrl.step) begin
         b_ff <= b_lo;
      end
      if (ctrl.clr)
         acc_ff <= '0;
      else if (ctrl.step)
         acc_ff <= acc_lo ^ gf_mul(a_ff, b_bcast, poly);
      else if (ctrl.drain)
         acc_ff <= acc_hi;
   end

   assign a_q   = a_ff;
   assign b_q   = b_ff;
   assign acc_q = acc_ff;
endmodule

// File: design/gpm_checker.sv
// Port-level checks on the multiplier, bound to the top level.
// Depends on gpm_pkg and gf4096_poly_mul_mod_defines.svh.
`include "gf4096_poly_mul_mod_defines.svh"
module gpm_checker import gpm_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input field_type rsp_coef,
   input logic      rsp_last
);
   `GPM_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `GPM_ASSERT_NEXT(a_last_ends, clock, rsp_valid && rsp_ready && rsp_last && !reset, !rsp_valid)
   `GPM_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && req_ready)
   `GPM_ASSERT_NEXT(a_hold, clock, rsp_valid && !rsp_ready && !reset, rsp_valid && $stable(rsp_coef) && $stable(rsp_last))
endmodule

bind gf4096_poly_mul_mod gpm_checker u_gpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_coef  (rsp_chan.coef_out),
   .rsp_last  (rsp_chan.last_out)
);

// File: sim/testbench.sv
// Testbench for gf4096_poly_mul_mod: streams operand rounds, predicts the reduced product.
// Depends on gpm_pkg, gpm_if and the block itself.
module testbench import gpm_pkg::*; ();

   class product_board;
      logic [11:0] field_low;
      logic [11:0] a_coefs[DEGREE];
      logic [11:0] b_coefs[DEGREE];
      int          pair_count;
      logic [12:0] want_q[$];   // {last, coef}
      int          errors;

      function new();
         field_low  = 12'd9;
         pair_count = 0;
         errors     = 0;
      endfunction

      function logic [11:0] fmul(logic [11:0] a, logic [11:0] b);
         logic [11:0] acc;
         acc = '0;
         for (int k = 11; k >= 0; k--) begin
            acc = {acc[10:0], 1'b0} ^ (acc[11] ? field_low : 12'd0);
            if (b[k]) acc = acc ^ a;
         end
         return acc;
      endfunction

      function void note_pair(logic [11:0] ca, logic [11:0] cb);
         logic [11:0] prod[2*DEGREE-1];
         logic [11:0] t;
         a_coefs[pair_count] = ca;
         b_coefs[pair_count] = cb;
         pair_count++;
         if (pair_count < DEGREE) return;
         pair_count = 0;
         foreach (prod[i]) prod[i] = '0;
         for (int i = 0; i < DEGREE; i++)
            for (int j = 0; j < DEGREE; j++)
               prod[i+j] ^= fmul(a_coefs[i], b_coefs[j]);
         // fold from the top so carries above DEGREE fold again
         for (int i = 2*DEGREE-2; i >= DEGREE; i--) begin
            t = prod[i];
            prod[i-DEGREE+3] ^= t;
            prod[i-DEGREE+1] ^= t;
            prod[i-DEGREE]   ^= fmul(t, 12'd2);
         end
         for (int k = 0; k < DEGREE; k++)
            want_q.push_back({k == DEGREE-1, prod[k]});
      endfunction

      task report_miss(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_coef(logic [11:0] coef, logic last);
         logic [12:0] w;
         if (want_q.size() == 0) begin
            report_miss("unexpected result beat");
            return;
         end
         w = want_q.pop_front();
         if (coef !== w[11:0]) report_miss($sformatf("coef %h, want %h", coef, w[11:0]));
         if (last !== w[12]) report_miss($sformatf("last %b, want %b", last, w[12]));
      endtask
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CSR_W-1:0] csr_wdata;
   gpm_req_if req_chan();
   gpm_rsp_if rsp_chan();
   product_board board;
   int idle_cycles = 0;
   bit stim_done;

   gf4096_poly_mul_mod i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stall pattern: randomly chosen modes of free flow and random stalls
   initial begin
      int mode_len;
      int mode;
      rsp_chan.ready = 0;
      forever begin
         mode = $urandom_range(0, 2);
         mode_len = $urandom_range(5, 80);
         repeat (mode_len) begin
            @(posedge clock);
            rsp_chan.ready <= (mode == 0) ? 1'b1 :
                              (mode == 1) ? ($urandom_range(0, 3) != 0) :
                              1'($urandom_range(0, 1));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_coef(rsp_chan.coef_out, rsp_chan.last_out);
         if (req_chan.valid && req_chan.ready)
            board.note_pair(req_chan.coef_a, req_chan.coef_b);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   int burst_left;

   // drives one pair; returns after it is accepted
   task automatic send_pair(logic [11:0] ca, logic [11:0] cb);
      if (burst_left == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_chan.valid  <= 1;
      req_chan.coef_a <= ca;
      req_chan.coef_b <= cb;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain_and_write(logic [11:0] poly);
      req_chan.valid <= 0;
      @(posedge clock);
      while (board.want_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= poly;
      @(posedge clock);
      csr_we <= 0;
      board.field_low = poly;
      @(posedge clock);
   endtask

   // kind: 0 random, 1 all max, 2 single term, 3 high terms only
   task automatic send_round(int kind);
      logic [11:0] ca, cb;
      for (int i = 0; i < DEGREE; i++) begin
         case (kind)
            1: begin
               ca = 12'hFFF; cb = 12'hFFF;
            end
            2: begin
               ca = (i == 0) ? 12'h001 : 12'h000; cb = (i == 0) ? 12'h800 : 12'h000;
            end
            3: begin
               ca = (i == DEGREE-1) ? 12'hFFF : 12'h000;
               cb = (i >= DEGREE-2) ? 12'hABC : 12'h000;
            end
            default: begin
               ca = 12'($urandom_range(0, 4095)); cb = 12'($urandom_range(0, 4095));
            end
         endcase
         send_pair(ca, cb);
      end
   endtask

   initial begin
      board = new();
      burst_left = 0;
      reset = 1;
      csr_we = 0;
      csr_wdata = '0;
      req_chan.valid = 0;
      req_chan.coef_a = '0;
      req_chan.coef_b = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset polynomial with all-max operands, then a new polynomial on random data
      send_round(1);
      drain_and_write(12'h053);   // x^12+x^6+x^4+x+1
      send_round(0);
      req_chan.valid <= 0;
      @(posedge clock);
      while (board.want_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/gpm_pkg.sv
design/gpm_if.sv
design/gpm_cell.sv
design/gf4096_poly_mul_mod.sv
design/gpm_checker.sv
sim/testbench.sv
